### src/sus_pkg.sv
// Package for the sorted unique set: field widths, request and result types, codes.
package sus_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int CMD_W    = 2;
  localparam int VAL_W    = 9;
  localparam int LIMIT_W  = 10;
  localparam int STATUS_W = 3;
  localparam int POS_W    = 6;
  localparam int COUNT_W  = 7;

  typedef logic [CMD_W-1:0]    cmd_t;
  typedef logic [VAL_W-1:0]    val_t;
  typedef logic [LIMIT_W-1:0]  limit_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [POS_W-1:0]    pos_t;
  typedef logic [COUNT_W-1:0]  count_t;
  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [CNT_W-1:0]    cnt_t;

  localparam cmd_t CMD_INSERT = 2'd0;
  localparam cmd_t CMD_DELETE = 2'd1;
  localparam cmd_t CMD_DUMP   = 2'd2;

  localparam status_t ST_DONE     = 3'd0;
  localparam status_t ST_DUP      = 3'd1;
  localparam status_t ST_FULL     = 3'd2;
  localparam status_t ST_RANGE    = 3'd3;
  localparam status_t ST_NOTFOUND = 3'd4;
  localparam status_t ST_ENTRY    = 3'd5;
  localparam status_t ST_EMPTY    = 3'd6;

  localparam limit_t LIMIT_RESET = 10'd500;

  typedef struct packed {
    cmd_t cmd;
    val_t value;
  } in_req_t;

  typedef struct packed {
    status_t status;
    val_t    value_res;
    pos_t    position;
    count_t  count;
    logic    last;
  } out_res_t;

endpackage

### src/sorted_unique_set.sv
// Sorted set of distinct values kept in a single-port-read table memory.
//
// A request is taken when start is high and busy is low. Insert and delete
// each give one result; a dump gives one result per held entry in ascending
// order, with last set on the final one, or a single empty result.
// Results appear on out_res for exactly one cycle, marked by out_valid;
// the receiver cannot stall them.
// The table memory has one read port with a registered output, so every step
// that looks at an entry presents the address in one state and uses the data in another:
//   insert or delete: S_SRCH and S_CMP for each entry compared, S_SHRD and S_SHWR
//     for each entry moved; a search and a shift together never cover more than
//     CAPACITY entries;
//   dump: S_DRD and S_DOUT for each entry, one result per entry;
//   out-of-range inserts and empty dumps: result in the next cycle.
// Command code 3 is dropped without a result. The limit register is written through
// cfg_we/cfg_wdata; the user must write it only while idle, which is not enforced.
// Reset empties the set, sets the limit to 500 and needs no clearing pass:
// only entries below the fill count are ever used.
module sorted_unique_set
  import sus_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  in_req_t  in_req,
  output logic     out_valid,
  output out_res_t out_res,
  input  logic     cfg_we,
  input  limit_t   cfg_wdata
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SRCH = 7'b0000010,
    S_CMP  = 7'b0000100,
    S_SHRD = 7'b0001000,
    S_SHWR = 7'b0010000,
    S_DRD  = 7'b0100000,
    S_DOUT = 7'b1000000
  } state_t;

  localparam cnt_t CAP_CNT = CNT_W'(CAPACITY);
  localparam cnt_t ONE     = CNT_W'(1);

  state_t   state_r, state_nxt;
  logic     is_del_r, is_del_nxt;
  val_t     val_r, val_nxt;
  cnt_t     cnt_r, cnt_nxt;
  cnt_t     idx_r, idx_nxt;
  cnt_t     pos_r, pos_nxt;
  limit_t   limit_r;
  logic     out_valid_r, out_valid_nxt;
  out_res_t out_res_r, out_res_nxt;

  val_t     mem [CAPACITY];
  val_t     rdata_r;
  idx_t     raddr;
  logic     we;
  idx_t     waddr;
  val_t     wdata;

  logic     srch_end;
  logic     found;
  logic     accept;

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_comb begin
    state_nxt     = state_r;
    is_del_nxt    = is_del_r;
    val_nxt       = val_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    pos_nxt       = pos_r;
    out_valid_nxt = 1'b0;
    out_res_nxt   = out_res_r;
    raddr         = idx_r[IDX_W-1:0];
    we            = 1'b0;
    waddr         = idx_r[IDX_W-1:0];
    wdata         = rdata_r;
    srch_end      = 1'b0;
    found         = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          val_nxt    = in_req.value;
          is_del_nxt = (in_req.cmd == CMD_DELETE);
          idx_nxt    = '0;
          if (in_req.cmd == CMD_INSERT && {1'b0, in_req.value} >= limit_r) begin
            out_valid_nxt = 1'b1;
            out_res_nxt   = '{ST_RANGE, in_req.value, '0, count_t'(cnt_r), 1'b1};
          end else if (in_req.cmd == CMD_INSERT || in_req.cmd == CMD_DELETE) begin
            state_nxt = S_SRCH;
          end else if (in_req.cmd == CMD_DUMP) begin
            if (cnt_r == '0) begin
              out_valid_nxt = 1'b1;
              out_res_nxt   = '{ST_EMPTY, '0, '0, '0, 1'b1};
            end else begin
              state_nxt = S_DRD;
            end
          end
        end
      end
      S_SRCH: begin
        if (idx_r == cnt_r) begin
          srch_end = 1'b1;
        end else begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (rdata_r < val_r) begin
          idx_nxt   = idx_r + ONE;
          state_nxt = S_SRCH;
        end else begin
          srch_end = 1'b1;
          found    = (rdata_r == val_r);
        end
      end
      S_SHRD: begin
        if (!is_del_r) begin
          // Entries above the insertion point have moved up by one.
          if (idx_r == pos_r) begin
            we            = 1'b1;
            wdata         = val_r;
            cnt_nxt       = cnt_r + ONE;
            out_valid_nxt = 1'b1;
            out_res_nxt   = '{ST_DONE, val_r, pos_t'(pos_r), count_t'(cnt_r + ONE), 1'b1};
            state_nxt     = S_IDLE;
          end else begin
            raddr     = idx_t'(idx_r - ONE);
            state_nxt = S_SHWR;
          end
        end else begin
          if (idx_r + ONE >= cnt_r) begin
            cnt_nxt       = cnt_r - ONE;
            out_valid_nxt = 1'b1;
            out_res_nxt   = '{ST_DONE, val_r, pos_t'(pos_r), count_t'(cnt_r - ONE), 1'b1};
            state_nxt     = S_IDLE;
          end else begin
            raddr     = idx_t'(idx_r + ONE);
            state_nxt = S_SHWR;
          end
        end
      end
      S_SHWR: begin
        // The read and the write of one move never fall in the same cycle.
        we        = 1'b1;
        wdata     = rdata_r;
        idx_nxt   = is_del_r ? idx_r + ONE : idx_r - ONE;
        state_nxt = S_SHRD;
      end
      S_DRD: begin
        state_nxt = S_DOUT;
      end
      S_DOUT: begin
        out_valid_nxt = 1'b1;
        out_res_nxt   = '{ST_ENTRY, rdata_r, pos_t'(idx_r), count_t'(cnt_r),
                          (idx_r + ONE == cnt_r)};
        if (idx_r + ONE == cnt_r) begin
          state_nxt = S_IDLE;
        end else begin
          idx_nxt   = idx_r + ONE;
          state_nxt = S_DRD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (srch_end) begin
      if (!is_del_r) begin
        if (found) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = '{ST_DUP, val_r, pos_t'(idx_r), count_t'(cnt_r), 1'b1};
          state_nxt     = S_IDLE;
        end else if (cnt_r >= CAP_CNT) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = '{ST_FULL, val_r, '0, count_t'(cnt_r), 1'b1};
          state_nxt     = S_IDLE;
        end else begin
          pos_nxt   = idx_r;
          idx_nxt   = cnt_r;
          state_nxt = S_SHRD;
        end
      end else begin
        if (found) begin
          pos_nxt   = idx_r;
          idx_nxt   = idx_r;
          state_nxt = S_SHRD;
        end else begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = '{ST_NOTFOUND, val_r, '0, count_t'(cnt_r), 1'b1};
          state_nxt     = S_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      limit_r     <= LIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    is_del_r  <= is_del_nxt;
    val_r     <= val_nxt;
    idx_r     <= idx_nxt;
    pos_r     <= pos_nxt;
    out_res_r <= out_res_nxt;
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CAP_CNT)
    else $error("fill count exceeds capacity");

  a_count_field: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_res.count == count_t'(cnt_r))
    else $error("reported count differs from held count");

  a_more_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_res.last) |-> busy)
    else $error("non-final result while idle");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.status == ST_DONE && !is_del_r)
      |-> cnt_r == $past(cnt_r) + ONE)
    else $error("stored insert did not grow the set by one");
`endif

endmodule

### dv/tb_sorted_unique_set.sv
// Testbench for the sorted unique set: directed table, then random requests, self-checked.
module tb_sorted_unique_set;
  timeunit 1ns;
  timeprecision 1ps;

  import sus_pkg::*;

  localparam cmd_t CMD_UNUSED = 2'd3;

  typedef struct packed {
    in_req_t  req;
    bit       typed;
    out_res_t res;
  } row_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  in_req_t  in_req = '0;
  logic     out_valid;
  out_res_t out_res;
  logic     cfg_we = 1'b0;
  limit_t   cfg_wdata = '0;

  // Software copy of the set and of the limit register.
  val_t        held [CAPACITY];
  int          n_held = 0;
  limit_t      lim = LIMIT_RESET;

  out_res_t    step_res [$];
  out_res_t    pending_res [$];
  row_t        plan [$];
  bit          row_typed = 1'b0;
  out_res_t    row_res = '0;
  int unsigned taken_cnt = 0;
  int unsigned err_cnt = 0;
  int unsigned burst_left = 0;

  sorted_unique_set uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic out_res_t mk_res(status_t st, int unsigned v, int unsigned p,
                                      int unsigned n, bit lst);
    out_res_t r;
    r.status    = st;
    r.value_res = val_t'(v);
    r.position  = pos_t'(p);
    r.count     = count_t'(n);
    r.last      = lst;
    return r;
  endfunction

  function automatic row_t mk_row(cmd_t c, int unsigned v, bit typed, out_res_t r);
    row_t w;
    w.req.cmd   = c;
    w.req.value = val_t'(v);
    w.typed     = typed;
    w.res       = r;
    return w;
  endfunction

  // Applies one request to the software set and leaves its results in step_res.
  function automatic void set_update(in_req_t r);
    int pos;
    int i;
    step_res.delete();
    pos = 0;
    while (pos < n_held && held[pos] < r.value) pos++;
    case (r.cmd)
      CMD_INSERT: begin
        if ({1'b0, r.value} >= lim) begin
          step_res.push_back(mk_res(ST_RANGE, r.value, 0, n_held, 1'b1));
        end else if (pos < n_held && held[pos] == r.value) begin
          step_res.push_back(mk_res(ST_DUP, r.value, pos, n_held, 1'b1));
        end else if (n_held >= CAPACITY) begin
          step_res.push_back(mk_res(ST_FULL, r.value, 0, n_held, 1'b1));
        end else begin
          for (i = n_held; i > pos; i--) held[i] = held[i-1];
          held[pos] = r.value;
          n_held++;
          step_res.push_back(mk_res(ST_DONE, r.value, pos, n_held, 1'b1));
        end
      end
      CMD_DELETE: begin
        if (pos >= n_held || held[pos] != r.value) begin
          step_res.push_back(mk_res(ST_NOTFOUND, r.value, 0, n_held, 1'b1));
        end else begin
          for (i = pos; i + 1 < n_held; i++) held[i] = held[i+1];
          n_held--;
          step_res.push_back(mk_res(ST_DONE, r.value, pos, n_held, 1'b1));
        end
      end
      CMD_DUMP: begin
        if (n_held == 0) begin
          step_res.push_back(mk_res(ST_EMPTY, 0, 0, 0, 1'b1));
        end else begin
          for (i = 0; i < n_held; i++)
            step_res.push_back(mk_res(ST_ENTRY, held[i], i, n_held, i + 1 == n_held));
        end
      end
      default: ;
    endcase
  endfunction

  task automatic check_result(out_res_t got);
    out_res_t want;
    if (pending_res.size() == 0) begin
      err_cnt++;
      if (err_cnt <= 10)
        $display("unexpected result: st=%0d v=%0d pos=%0d cnt=%0d last=%0d",
                 got.status, got.value_res, got.position, got.count, got.last);
    end else begin
      want = pending_res.pop_front();
      if (got.status !== want.status || got.value_res !== want.value_res ||
          got.position !== want.position || got.count !== want.count ||
          got.last !== want.last) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("mismatch: exp st=%0d v=%0d pos=%0d cnt=%0d last=%0d, %s",
                   want.status, want.value_res, want.position, want.count, want.last,
                   $sformatf("got st=%0d v=%0d pos=%0d cnt=%0d last=%0d",
                             got.status, got.value_res, got.position, got.count,
                             got.last));
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) check_result(out_res);
      if (start && !busy) begin
        set_update(in_req);
        // Hand-written rows replace the prediction; the software set still advances.
        if (row_typed) pending_res.push_back(row_res);
        else foreach (step_res[k]) pending_res.push_back(step_res[k]);
        taken_cnt++;
      end
    end
  end

  // Leaves start high once the request is taken, so a following request can go out
  // on the same falling edge.
  task automatic issue(in_req_t r);
    int unsigned seen;
    seen = taken_cnt;
    in_req = r;
    start = 1'b1;
    do @(negedge clk); while (taken_cnt == seen);
  endtask

  task automatic pace();
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      start = 1'b0;
      if ($urandom_range(0, 7) == 0) repeat ($urandom_range(20, 60)) @(negedge clk);
      else repeat ($urandom_range(0, 5)) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
  endtask

  task automatic set_limit(limit_t l);
    start = 1'b0;
    while (pending_res.size() != 0) @(negedge clk);
    // A dropped request leaves nothing to wait for, so give the block time to settle.
    repeat (16) @(negedge clk);
    while (busy) @(negedge clk);
    cfg_wdata = l;
    cfg_we = 1'b1;
    lim = l;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic in_req_t rand_req(int unsigned w_ins, int unsigned w_del,
                                       int unsigned w_dump);
    in_req_t     r;
    int unsigned pick;
    int          x;
    pick = $urandom_range(0, w_ins + w_del + w_dump);
    if (pick < w_ins) r.cmd = CMD_INSERT;
    else if (pick < w_ins + w_del) r.cmd = CMD_DELETE;
    else if (pick < w_ins + w_del + w_dump) r.cmd = CMD_DUMP;
    else r.cmd = CMD_UNUSED;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        if (n_held > 0) r.value = held[$urandom_range(0, n_held - 1)];
        else r.value = val_t'($urandom_range(0, 511));
      end
      3: begin
        x = int'(lim) + int'($urandom_range(0, 2)) - 1;
        if (x < 0) x = 0;
        if (x > 511) x = 511;
        r.value = val_t'(x);
      end
      4: r.value = $urandom_range(0, 1) ? val_t'(511) : val_t'(0);
      default: r.value = val_t'($urandom_range(0, 511));
    endcase
    return r;
  endfunction

  task automatic run_random(int unsigned n, int unsigned w_ins, int unsigned w_del,
                            int unsigned w_dump);
    repeat (n) begin
      issue(rand_req(w_ins, w_del, w_dump));
      pace();
    end
  endtask

  initial begin
    in_req_t r;
    plan.push_back(mk_row(CMD_DUMP,   0,   1, mk_res(ST_EMPTY,    0,   0, 0, 1'b1)));
    plan.push_back(mk_row(CMD_DELETE, 5,   1, mk_res(ST_NOTFOUND, 5,   0, 0, 1'b1)));
    plan.push_back(mk_row(CMD_INSERT, 511, 1, mk_res(ST_RANGE,    511, 0, 0, 1'b1)));
    plan.push_back(mk_row(CMD_INSERT, 500, 1, mk_res(ST_RANGE,    500, 0, 0, 1'b1)));
    plan.push_back(mk_row(CMD_INSERT, 499, 1, mk_res(ST_DONE,     499, 0, 1, 1'b1)));
    plan.push_back(mk_row(CMD_INSERT, 0,   1, mk_res(ST_DONE,     0,   0, 2, 1'b1)));
    plan.push_back(mk_row(CMD_INSERT, 0,   1, mk_res(ST_DUP,      0,   0, 2, 1'b1)));
    plan.push_back(mk_row(CMD_INSERT, 499, 1, mk_res(ST_DUP,      499, 1, 2, 1'b1)));
    plan.push_back(mk_row(CMD_INSERT, 250, 0, '0));
    plan.push_back(mk_row(CMD_UNUSED, 511, 0, '0));
    plan.push_back(mk_row(CMD_INSERT, 300, 0, '0));
    plan.push_back(mk_row(CMD_DUMP,   0,   0, '0));
    plan.push_back(mk_row(CMD_DELETE, 250, 0, '0));
    plan.push_back(mk_row(CMD_DELETE, 250, 1, mk_res(ST_NOTFOUND, 250, 0, 3, 1'b1)));
    plan.push_back(mk_row(CMD_DELETE, 0,   0, '0));
    plan.push_back(mk_row(CMD_DUMP,   511, 0, '0));
    plan.push_back(mk_row(CMD_UNUSED, 0,   0, '0));
    plan.push_back(mk_row(CMD_INSERT, 1,   0, '0));
    plan.push_back(mk_row(CMD_INSERT, 499, 1, mk_res(ST_DUP,      499, 2, 3, 1'b1)));
    plan.push_back(mk_row(CMD_DELETE, 499, 0, '0));
    plan.push_back(mk_row(CMD_DUMP,   0,   0, '0));

    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (plan[i]) begin
      row_typed = plan[i].typed;
      row_res = plan[i].res;
      issue(plan[i].req);
      pace();
    end
    row_typed = 1'b0;

    // Widest limit: fill the table, then hit it while full with inserts and dumps.
    set_limit(limit_t'(1023));
    while (n_held < CAPACITY) begin
      r.cmd = CMD_INSERT;
      r.value = val_t'($urandom_range(0, 511));
      issue(r);
      pace();
    end
    run_random(30, 70, 0, 29);

    // Nothing can be stored, and out of range must win over a full table.
    set_limit(limit_t'(0));
    run_random(40, 40, 40, 19);

    // Lowered limit with larger values still held; deletes must still find them.
    set_limit(limit_t'(100));
    run_random(120, 45, 40, 14);

    set_limit(limit_t'(1));
    run_random(30, 50, 30, 19);

    set_limit(limit_t'(512));
    run_random(150, 45, 35, 19);

    start = 1'b0;
    while (pending_res.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (err_cnt == 0 && pending_res.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
